### rtl/fra_pkg.sv
// shared types, constants and checksum helper for the fragment reassembler
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;

  localparam int FRAGMENT_BYTES_DEF = 624;
  localparam int HEADER_BYTES       = 16;
  localparam int PACKET_BYTES_DEF   = 2048;

  localparam int MIN_PACKET   = 34;
  localparam int PROTO_POS    = 23;
  localparam int IP_CSUM_POS  = 24;
  localparam int SRC_IP_POS   = 26;
  localparam int DST_IP_POS   = 30;
  localparam int TCP_CSUM_POS = 50;
  localparam int IP_SUM_FIRST = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_IP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC = 2'd3;

  localparam logic [31:0] MATCH_IP_RST   = 32'd3232235620;
  localparam logic [31:0] NEW_IP_RST     = 32'd3232236132;
  localparam logic [47:0] DEST_MAC_RST   = 48'd150737334935;
  localparam logic [47:0] SOURCE_MAC_RST = 48'd220590336660418;

  localparam logic [2:0] ST_KEPT     = 3'd0;
  localparam logic [2:0] ST_ORDER    = 3'd1;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_BADLEN   = 3'd4;
  localparam logic [2:0] ST_OUTBUSY  = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [11:0] packet_length;
  } res_t;

  typedef struct packed {
    logic launch;
    logic copy_last;
    logic csum_last;
  } fra_stat_t;

  typedef struct packed {
    logic copy_rd;
    logic csum_wr;
    logic finish;
    logic busy;
  } fra_cmd_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] csum_add(input logic [15:0] sum, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, sum} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage
`default_nettype wire

### rtl/fra_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic       [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/fra_ctrl.sv
// controller for the copy, rewrite and checksum sequence
`timescale 1ns / 1ps
`default_nettype none
module fra_ctrl import fra_pkg::*; (
  input  wire  logic      clk,
  input  wire  logic      rst,
  input  wire  fra_stat_t stat,
  output fra_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COPY  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_CSUM  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.copy_rd = 1'b0;
    cmd.csum_wr = 1'b0;
    cmd.finish  = 1'b0;
    cmd.busy    = 1'b1;
    case (state)
      S_IDLE: begin
        cmd.busy = 1'b0;
        if (stat.launch) begin
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (stat.copy_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_CSUM;
      end
      S_CSUM: begin
        cmd.csum_wr = 1'b1;
        if (stat.csum_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/fra_datapath.sv
// datapath: fragment parsing, assembly and output stores, rewrite and checksums
`timescale 1ns / 1ps
`default_nettype none
module fra_datapath import fra_pkg::*; #(
  parameter int FRAGMENT_BYTES = FRAGMENT_BYTES_DEF,
  parameter int PACKET_BYTES   = PACKET_BYTES_DEF
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst,
  input  wire  logic                  start,
  input  wire  req_t                  request,
  input  wire  logic                  cfg_we,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [CFG_DATA_W-1:0] cfg_data,
  input  wire  fra_cmd_t              cmd,
  output fra_stat_t                   stat,
  output logic                        done,
  output res_t                        result
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int LW = $clog2(PACKET_BYTES + 1);
  localparam int FW = $clog2(FRAGMENT_BYTES);
  localparam int PW = $clog2(PACKET_BYTES + FRAGMENT_BYTES);

  logic [31:0] match_ip, new_ip;
  logic [47:0] dest_mac, source_mac;

  logic [FW-1:0] bif;
  logic [31:0]   expected, hpl, hfc, hid;
  logic [LW-1:0] assembled;
  logic          overflow;
  logic [31:0]   dst, dst_next;

  logic          pending;
  logic [LW-1:0] out_len, rd_idx;

  logic [LW-1:0] copy_len, rd_addr, wr_addr;
  logic          wr_vld;
  logic [15:0]   ip_sum, tcp_sum;
  logic [1:0]    csum_cnt;

  logic          res_valid, res_is_read, res_last;
  logic [2:0]    res_status;
  logic [11:0]   res_len;

  logic [7:0]    asm_q, out_q;

  // request side
  logic          accept, push, rd;
  logic [7:0]    b;
  logic [FW-1:0] p;
  logic [PW-1:0] pos;
  logic          payload_ok, p_in, pos_ok, asm_we, ovf_hit, ovf_next, last_byte;
  logic [32:0]   sum33;
  logic [LW-1:0] len;
  logic [2:0]    fin_st;
  logic          drop, adv, go;

  assign accept = start && !cmd.busy;
  assign push   = accept && !request.cmd;
  assign rd     = accept && request.cmd;
  assign b      = request.in_byte;

  assign p          = bif - FW'(HEADER_BYTES);
  assign payload_ok = (bif >= FW'(HEADER_BYTES)) && (hid == expected);
  assign p_in       = 32'(p) < hpl;
  assign pos        = PW'(assembled) + PW'(p);
  assign pos_ok     = pos < PW'(PACKET_BYTES);
  assign asm_we     = push && payload_ok && p_in && pos_ok;
  assign ovf_hit    = push && payload_ok && p_in && !pos_ok;
  assign ovf_next   = overflow || ovf_hit;
  assign last_byte  = bif == FW'(FRAGMENT_BYTES - 1);
  assign sum33      = {1'b0, 32'(assembled)} + {1'b0, hpl};
  assign len        = assembled + hpl[LW-1:0];

  // keep the destination ip bytes as they go into the assembly
  always_comb begin
    dst_next = dst;
    if (asm_we && pos >= PW'(DST_IP_POS) && pos <= PW'(DST_IP_POS + 3)) begin
      dst_next[{2'(2'd3 - 2'(pos[1:0] - 2'd2)), 3'b000} +: 8] = b;
    end
  end

  always_comb begin
    fin_st = ST_KEPT;
    drop   = 1'b0;
    adv    = 1'b0;
    go     = 1'b0;
    if (hid != expected) begin
      fin_st = ST_ORDER;
      drop   = 1'b1;
    end else if (ovf_next || hpl > 32'(FRAGMENT_BYTES - HEADER_BYTES) ||
                 sum33 > 33'(PACKET_BYTES)) begin
      fin_st = ST_BADLEN;
      drop   = 1'b1;
    end else if (hid == hfc) begin
      drop = 1'b1;
      if (len < LW'(MIN_PACKET)) begin
        fin_st = ST_BADLEN;
      end else if (dst_next != match_ip) begin
        fin_st = ST_MISMATCH;
      end else if (pending) begin
        fin_st = ST_OUTBUSY;
      end else begin
        go = 1'b1;
      end
    end else begin
      adv = 1'b1;
    end
  end

  assign stat.launch    = push && last_byte && go;
  assign stat.copy_last = rd_addr == copy_len - LW'(1);
  assign stat.csum_last = csum_cnt == 2'd3;

  // rewrite stage of the copy
  logic [7:0]  wb;
  logic [15:0] word;
  logic [47:0] dm_sh, sm_sh;
  logic [31:0] ip_sh;
  logic        in_ip, in_tcp;

  assign dm_sh = dest_mac >> {3'(3'd5 - wr_addr[2:0]), 3'b000};
  assign sm_sh = source_mac >> {3'(3'd5 - 3'(wr_addr[3:0] - 4'd6)), 3'b000};
  assign ip_sh = new_ip >> {2'(2'd3 - 2'(wr_addr[1:0] - 2'd2)), 3'b000};

  always_comb begin
    if (wr_addr < LW'(6)) begin
      wb = dm_sh[7:0];
    end else if (wr_addr < LW'(12)) begin
      wb = sm_sh[7:0];
    end else if (wr_addr >= LW'(DST_IP_POS) && wr_addr <= LW'(DST_IP_POS + 3)) begin
      wb = ip_sh[7:0];
    end else begin
      wb = asm_q;
    end
  end

  assign word   = wr_addr[0] ? {8'h00, wb} : {wb, 8'h00};
  assign in_ip  = wr_addr >= LW'(IP_SUM_FIRST) && wr_addr < LW'(MIN_PACKET) &&
                  wr_addr != LW'(IP_CSUM_POS) && wr_addr != LW'(IP_CSUM_POS + 1);
  assign in_tcp = wr_addr >= LW'(SRC_IP_POS) &&
                  wr_addr != LW'(TCP_CSUM_POS) && wr_addr != LW'(TCP_CSUM_POS + 1);

  // output store write port
  logic          out_we;
  logic [AW-1:0] out_waddr;
  logic [7:0]    out_wdata;

  always_comb begin
    out_we    = wr_vld || cmd.csum_wr;
    out_waddr = wr_addr[AW-1:0];
    out_wdata = wb;
    if (cmd.csum_wr) begin
      case (csum_cnt)
        2'd0: begin
          out_waddr = AW'(IP_CSUM_POS);
          out_wdata = ~ip_sum[15:8];
        end
        2'd1: begin
          out_waddr = AW'(IP_CSUM_POS + 1);
          out_wdata = ~ip_sum[7:0];
        end
        2'd2: begin
          out_waddr = AW'(TCP_CSUM_POS);
          out_wdata = ~tcp_sum[15:8];
        end
        default: begin
          out_waddr = AW'(TCP_CSUM_POS + 1);
          out_wdata = ~tcp_sum[7:0];
        end
      endcase
    end
  end

  fra_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_asm_ram (
    .clk   (clk),
    .we    (asm_we),
    .waddr (pos[AW-1:0]),
    .wdata (b),
    .raddr (rd_addr[AW-1:0]),
    .q     (asm_q)
  );

  fra_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (rd_idx[AW-1:0]),
    .q     (out_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      match_ip   <= MATCH_IP_RST;
      new_ip     <= NEW_IP_RST;
      dest_mac   <= DEST_MAC_RST;
      source_mac <= SOURCE_MAC_RST;
      bif        <= '0;
      expected   <= 32'd1;
      hpl        <= '0;
      hfc        <= '0;
      hid        <= '0;
      assembled  <= '0;
      overflow   <= 1'b0;
      pending    <= 1'b0;
      out_len    <= '0;
      rd_idx     <= '0;
      wr_vld     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH_IP:   match_ip   <= cfg_data[31:0];
          REG_NEW_IP:     new_ip     <= cfg_data[31:0];
          REG_DEST_MAC:   dest_mac   <= cfg_data;
          REG_SOURCE_MAC: source_mac <= cfg_data;
          default: ;
        endcase
      end

      res_valid <= 1'b0;
      wr_vld    <= cmd.copy_rd;

      if (push) begin
        if (bif >= FW'(4) && bif < FW'(HEADER_BYTES)) begin
          case (bif[3:2])
            2'd1:    hpl[{bif[1:0], 3'b000} +: 8] <= b;
            2'd2:    hfc[{bif[1:0], 3'b000} +: 8] <= b;
            default: hid[{bif[1:0], 3'b000} +: 8] <= b;
          endcase
        end
        overflow <= ovf_next;
        if (last_byte) begin
          bif <= '0;
          if (drop) begin
            expected  <= 32'd1;
            assembled <= '0;
            overflow  <= 1'b0;
          end
          if (adv) begin
            expected  <= expected + 32'd1;
            assembled <= len;
          end
          if (!go) begin
            res_valid   <= 1'b1;
            res_status  <= fin_st;
            res_is_read <= 1'b0;
            res_last    <= 1'b0;
            res_len     <= '0;
          end
        end else begin
          bif <= bif + FW'(1);
        end
      end

      if (rd) begin
        res_valid <= 1'b1;
        res_len   <= '0;
        if (!pending || rd_idx >= out_len) begin
          res_status  <= ST_EMPTY;
          res_is_read <= 1'b0;
          res_last    <= 1'b0;
        end else begin
          res_status  <= ST_READ;
          res_is_read <= 1'b1;
          if (rd_idx + LW'(1) >= out_len) begin
            res_last <= 1'b1;
            pending  <= 1'b0;
            rd_idx   <= '0;
          end else begin
            res_last <= 1'b0;
            rd_idx   <= rd_idx + LW'(1);
          end
        end
      end

      if (cmd.finish) begin
        pending     <= 1'b1;
        out_len     <= copy_len;
        rd_idx      <= '0;
        res_valid   <= 1'b1;
        res_status  <= ST_READY;
        res_is_read <= 1'b0;
        res_last    <= 1'b0;
        res_len     <= 12'(copy_len);
      end
    end
  end

  // payload registers of the copy and checksum walk
  always_ff @(posedge clk) begin
    dst <= dst_next;
    if (stat.launch) begin
      copy_len <= len;
      rd_addr  <= '0;
      csum_cnt <= '0;
      ip_sum   <= '0;
      tcp_sum  <= 16'(len - LW'(MIN_PACKET));
    end
    if (cmd.copy_rd) begin
      rd_addr <= rd_addr + LW'(1);
    end
    wr_addr <= rd_addr;
    if (wr_vld) begin
      if (in_ip) begin
        ip_sum <= csum_add(ip_sum, word);
      end
      if (in_tcp) begin
        tcp_sum <= csum_add(tcp_sum, word);
      end else if (wr_addr == LW'(PROTO_POS)) begin
        tcp_sum <= csum_add(tcp_sum, {8'h00, wb});
      end
    end
    if (cmd.csum_wr) begin
      csum_cnt <= csum_cnt + 2'd1;
    end
  end

  assign done                 = res_valid;
  assign result.status        = res_status;
  assign result.out_byte      = res_is_read ? out_q : 8'h00;
  assign result.out_last      = res_last;
  assign result.packet_length = res_len;

endmodule
`default_nettype wire

### rtl/fragment_reassembler_ip_rewriter.sv
// fragment push requests: one per cycle while busy is low, result in the cycle after the final fragment byte
// a matching packet adds a copy walk (copy, drain, four checksum writes)
// and busy is high throughout; byte reads are taken back to back, each result in the next cycle
// results carry a one-cycle done strobe and cannot be held off by the receiver
// synchronous active-high reset clears control state and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembler_ip_rewriter import fra_pkg::*; #(
  parameter int FRAGMENT_BYTES = FRAGMENT_BYTES_DEF,
  parameter int PACKET_BYTES   = PACKET_BYTES_DEF
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst,
  input  wire  logic                  start,
  output logic                        busy,
  input  wire  req_t                  request,
  input  wire  logic                  cfg_we,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                        done,
  output res_t                        result
);

  fra_cmd_t  cmd;
  fra_stat_t stat;

  fra_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  fra_datapath #(
    .FRAGMENT_BYTES (FRAGMENT_BYTES),
    .PACKET_BYTES   (PACKET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

  assign busy = cmd.busy;

endmodule
`default_nettype wire

### tb/fragment_reassembler_ip_rewriter_test.sv
// self-checking testbench for the fragment reassembler with ip/tcp header rewrite
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembler_ip_rewriter_test;
  import fra_pkg::*;

  localparam int FRAG        = FRAGMENT_BYTES_DEF;
  localparam int PAYLOAD_MAX = FRAGMENT_BYTES_DEF - HEADER_BYTES;
  localparam int PKT         = PACKET_BYTES_DEF;
  localparam int CYCLE_LIMIT = 6000000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  request;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  res_t                  result;

  fragment_reassembler_ip_rewriter i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // shadow of the block state
  logic [7:0]  asm_mem [PKT];
  logic [7:0]  out_mem [PKT];
  logic [31:0] want_id, asm_len, pos_in_frag, hdr_len, hdr_cnt, hdr_id;
  logic [31:0] out_len, rd_idx;
  bit          ovf, held;
  logic [31:0] cfg_match, cfg_newip;
  logic [47:0] cfg_dmac, cfg_smac;

  res_t        pending_q[$];
  int unsigned errors, cycles, n_frag_res, n_ready, n_reads, n_items;

  function automatic int unsigned ones_fold(int unsigned s, int unsigned w);
    s = s + (w & 32'hffff);
    return (s & 32'hffff) + (s >> 16);
  endfunction

  function automatic int unsigned pair_at(int p);
    return {out_mem[p], out_mem[p+1]};
  endfunction

  function automatic logic [2:0] close_packet();
    int unsigned len, sum, tlen, lo;
    len = asm_len;
    if (len < MIN_PACKET) return ST_BADLEN;
    for (int i = 0; i < 4; i++)
      if (asm_mem[DST_IP_POS+i] != cfg_match[31-8*i -: 8]) return ST_MISMATCH;
    if (held) return ST_OUTBUSY;
    for (int i = 0; i < len; i++) out_mem[i] = asm_mem[i];
    for (int i = 0; i < 6; i++) begin
      out_mem[i]   = cfg_dmac[47-8*i -: 8];
      out_mem[6+i] = cfg_smac[47-8*i -: 8];
    end
    for (int i = 0; i < 4; i++) out_mem[DST_IP_POS+i] = cfg_newip[31-8*i -: 8];
    out_mem[IP_CSUM_POS] = 8'd0;
    out_mem[IP_CSUM_POS+1] = 8'd0;
    sum = 0;
    for (int i = IP_SUM_FIRST; i < MIN_PACKET; i += 2) sum = ones_fold(sum, pair_at(i));
    out_mem[IP_CSUM_POS]   = ~sum[15:8];
    out_mem[IP_CSUM_POS+1] = ~sum[7:0];
    // tcp sum: pseudo-header, then segment padded with a zero byte when its length is odd
    out_mem[TCP_CSUM_POS] = 8'd0;
    out_mem[TCP_CSUM_POS+1] = 8'd0;
    tlen = len - MIN_PACKET;
    sum = 0;
    sum = ones_fold(sum, pair_at(SRC_IP_POS));
    sum = ones_fold(sum, pair_at(SRC_IP_POS+2));
    sum = ones_fold(sum, pair_at(DST_IP_POS));
    sum = ones_fold(sum, pair_at(DST_IP_POS+2));
    sum = ones_fold(sum, out_mem[PROTO_POS]);
    sum = ones_fold(sum, tlen);
    for (int i = MIN_PACKET; i < len; i += 2) begin
      lo = (i + 1 < len) ? out_mem[i+1] : 0;
      sum = ones_fold(sum, (out_mem[i] << 8) | lo);
    end
    out_mem[TCP_CSUM_POS]   = ~sum[15:8];
    out_mem[TCP_CSUM_POS+1] = ~sum[7:0];
    held = 1'b1;
    out_len = len;
    rd_idx = 0;
    return ST_READY;
  endfunction

  function automatic void restart_assembly();
    want_id = 1;
    asm_len = 0;
    ovf = 1'b0;
  endfunction

  // advances the shadow state by one request and queues its result, if any
  function automatic void reassemble_step(req_t r);
    res_t        e;
    logic [31:0] idx, p, pos;
    int          sh;
    e = '0;
    if (r.cmd) begin
      if (!held || rd_idx >= out_len || rd_idx >= PKT) begin
        e.status = ST_EMPTY;
      end else begin
        e.status = ST_READ;
        e.out_byte = out_mem[rd_idx];
        rd_idx++;
        if (rd_idx >= out_len) begin
          e.out_last = 1'b1;
          held = 1'b0;
          rd_idx = 0;
        end
      end
      pending_q.push_back(e);
      return;
    end
    idx = pos_in_frag;
    if (idx >= 4 && idx < HEADER_BYTES) begin
      sh = 8 * (idx % 4);
      if (idx < 8) hdr_len[sh +: 8] = r.in_byte;
      else if (idx < 12) hdr_cnt[sh +: 8] = r.in_byte;
      else hdr_id[sh +: 8] = r.in_byte;
    end else if (idx >= HEADER_BYTES && hdr_id == want_id) begin
      p = idx - HEADER_BYTES;
      if (p < hdr_len) begin
        pos = asm_len + p;
        if (pos < PKT) asm_mem[pos] = r.in_byte;
        else ovf = 1'b1;
      end
    end
    if (idx + 1 < FRAG) begin
      pos_in_frag = idx + 1;
      return;
    end
    pos_in_frag = 0;
    if (hdr_id != want_id) begin
      restart_assembly();
      e.status = ST_ORDER;
    end else if (ovf || hdr_len > PAYLOAD_MAX || asm_len + hdr_len > PKT) begin
      restart_assembly();
      e.status = ST_BADLEN;
    end else begin
      asm_len = asm_len + hdr_len;
      if (hdr_id == hdr_cnt) begin
        e.status = close_packet();
        if (e.status == ST_READY) e.packet_length = out_len[11:0];
        restart_assembly();
      end else begin
        want_id++;
        e.status = ST_KEPT;
      end
    end
    pending_q.push_back(e);
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d", result.status);
        errors++;
      end else begin
        res_t w;
        w = pending_q.pop_front();
        if (result.status != w.status) begin
          $error("status: expected %0d, got %0d", w.status, result.status); errors++;
        end
        if (result.out_byte != w.out_byte) begin
          $error("out_byte: expected %0h, got %0h", w.out_byte, result.out_byte); errors++;
        end
        if (result.out_last != w.out_last) begin
          $error("out_last: expected %0d, got %0d", w.out_last, result.out_last); errors++;
        end
        if (result.packet_length != w.packet_length) begin
          $error("packet_length: expected %0d, got %0d", w.packet_length,
                 result.packet_length);
          errors++;
        end
        if (result.status == ST_READ) n_reads++;
        else if (result.status != ST_EMPTY) n_frag_res++;
        if (result.status == ST_READY) n_ready++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // leaves start high when the next request follows with no gap
  task automatic issue(req_t r, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    reassemble_step(r);
    n_items++;
  endtask

  function automatic int draw_gap(bit idle);
    return idle ? $urandom_range(0, 19) : 0;
  endfunction

  // one whole fragment; hit steers the destination ip bytes onto or off match_ip
  task automatic send_fragment(logic [31:0] id, logic [31:0] cnt, logic [31:0] plen, bit hit);
    req_t        r;
    bit          idle;
    logic [31:0] base, pos;
    idle = $urandom_range(0, 1);
    base = asm_len;
    for (int i = 0; i < FRAG; i++) begin
      r.cmd = 1'b0;
      r.in_byte = $urandom_range(0, 255);
      if (i >= 4 && i < 8) r.in_byte = plen[8*(i-4) +: 8];
      else if (i >= 8 && i < 12) r.in_byte = cnt[8*(i-8) +: 8];
      else if (i >= 12 && i < 16) r.in_byte = id[8*(i-12) +: 8];
      else if (i >= HEADER_BYTES) begin
        pos = base + i - HEADER_BYTES;
        if (pos >= DST_IP_POS && pos < DST_IP_POS + 4) begin
          r.in_byte = cfg_match[31-8*(pos-DST_IP_POS) -: 8];
          if (!hit && pos == DST_IP_POS) r.in_byte = ~r.in_byte;
        end
      end
      issue(r, draw_gap(idle));
    end
  endtask

  // n == 0 reads whatever is left of the held packet, at least one read
  task automatic read_bytes(int n);
    req_t r;
    bit   idle;
    idle = $urandom_range(0, 1);
    if (n == 0) n = (held && out_len > rd_idx) ? out_len - rd_idx : 1;
    repeat (n) begin
      r.cmd = 1'b1;
      r.in_byte = $urandom_range(0, 255);
      issue(r, draw_gap(idle));
    end
  endtask

  // drops start first so a request is never taken twice
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] m, logic [31:0] n, logic [47:0] d, logic [47:0] s);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_MATCH_IP; cfg_data <= {16'd0, m};
    @(negedge clk);
    cfg_index <= REG_NEW_IP; cfg_data <= {16'd0, n};
    @(negedge clk);
    cfg_index <= REG_DEST_MAC; cfg_data <= d;
    @(negedge clk);
    cfg_index <= REG_SOURCE_MAC; cfg_data <= s;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_match = m; cfg_newip = n; cfg_dmac = d; cfg_smac = s;
  endtask

  // a well-formed packet split into in-order fragments
  task automatic send_packet(int len, bit hit);
    int parts[$];
    int rem;
    rem = len;
    if (rem == 0) parts.push_back(0);
    while (rem > 0) begin
      parts.push_back(rem < 200 ? rem : $urandom_range(200, rem < PAYLOAD_MAX ? rem : PAYLOAD_MAX));
      rem -= parts[$];
    end
    foreach (parts[k]) send_fragment(k + 1, parts.size(), parts[k], hit);
  endtask

  typedef enum logic {ROW_FRAG, ROW_READ} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic [31:0] id, cnt, plen;
    bit          hit;
    int          n;
    bit          pin;
    logic [2:0]  st;
  } row_t;

  row_t rows[$];

  initial begin
    rst = 1'b1; start = 1'b0; request = '0;
    cfg_we = 1'b0; cfg_index = REG_MATCH_IP; cfg_data = '0;
    errors = 0; cycles = 0; n_frag_res = 0; n_ready = 0; n_reads = 0; n_items = 0;
    foreach (asm_mem[i]) begin
      asm_mem[i] = 8'd0;
      out_mem[i] = 8'd0;
    end
    restart_assembly();
    pos_in_frag = 0; hdr_len = 0; hdr_cnt = 0; hdr_id = 0;
    held = 1'b0; out_len = 0; rd_idx = 0;
    cfg_match = MATCH_IP_RST; cfg_newip = NEW_IP_RST;
    cfg_dmac = DEST_MAC_RST; cfg_smac = SOURCE_MAC_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      '{ROW_READ, 0, 0, 0, 0, 1, 1, ST_EMPTY},
      '{ROW_FRAG, 1, 1, 100, 1, 0, 1, ST_READY},
      '{ROW_READ, 0, 0, 0, 0, 0, 0, ST_READ},
      '{ROW_READ, 0, 0, 0, 0, 1, 1, ST_EMPTY},
      '{ROW_FRAG, 2, 2, 50, 1, 0, 1, ST_ORDER},
      '{ROW_FRAG, 1, 1, 20, 1, 0, 1, ST_BADLEN},
      '{ROW_FRAG, 1, 1, PAYLOAD_MAX + 1, 1, 0, 1, ST_BADLEN},
      '{ROW_FRAG, 1, 1, 100, 0, 0, 1, ST_MISMATCH},
      '{ROW_FRAG, 1, 1, MIN_PACKET, 1, 0, 1, ST_READY},
      '{ROW_FRAG, 1, 1, 35, 1, 0, 1, ST_OUTBUSY},
      '{ROW_READ, 0, 0, 0, 0, 0, 0, ST_READ},
      '{ROW_FRAG, 1, 1, 35, 1, 0, 1, ST_READY},
      '{ROW_READ, 0, 0, 0, 0, 0, 0, ST_READ},
      '{ROW_FRAG, 1, 4, PAYLOAD_MAX, 1, 0, 1, ST_KEPT},
      '{ROW_FRAG, 2, 4, PAYLOAD_MAX, 1, 0, 1, ST_KEPT},
      '{ROW_FRAG, 3, 4, PAYLOAD_MAX, 1, 0, 1, ST_KEPT},
      '{ROW_FRAG, 4, 4, PKT - 3 * PAYLOAD_MAX, 1, 0, 1, ST_READY},
      '{ROW_READ, 0, 0, 0, 0, 0, 0, ST_READ},
      '{ROW_FRAG, 1, 9, PAYLOAD_MAX, 1, 0, 1, ST_KEPT},
      '{ROW_FRAG, 2, 9, PAYLOAD_MAX, 1, 0, 1, ST_KEPT},
      '{ROW_FRAG, 3, 9, PAYLOAD_MAX, 1, 0, 1, ST_KEPT},
      '{ROW_FRAG, 4, 9, PAYLOAD_MAX, 1, 0, 1, ST_BADLEN},
      '{ROW_FRAG, 1, 1, 0, 1, 0, 1, ST_BADLEN}
    };
    foreach (rows[k]) begin
      if (rows[k].kind == ROW_FRAG)
        send_fragment(rows[k].id, rows[k].cnt, rows[k].plen, rows[k].hit);
      else
        read_bytes(rows[k].n);
      if (rows[k].pin) pending_q[$].status = rows[k].st;
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: write_regs('0, '0, '0, '0);
        1: write_regs('1, '1, '1, '1);
        default: write_regs($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      for (int s = 0; s < 15; s++) begin
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) begin
          int len, sel;
          sel = $urandom_range(0, 99);
          len = sel < 85 ? $urandom_range(MIN_PACKET, 400) :
                sel < 95 ? $urandom_range(401, PKT) : $urandom_range(0, MIN_PACKET - 1);
          send_packet(len, $urandom_range(0, 99) < 85);
          sel = $urandom_range(0, 99);
          if (sel < 70) read_bytes(0);
          else if (sel < 85) read_bytes($urandom_range(1, 40));
        end else if (k < 75) begin
          read_bytes($urandom_range(1, 8));
        end else if (k < 85) begin
          send_fragment($urandom_range(2, 5), $urandom_range(1, 5), $urandom_range(0, 300), 1);
        end else if (k < 95) begin
          send_fragment(1, 1, $urandom_range(0, 1) ? $urandom : $urandom_range(609, 1023), 1);
        end else begin
          // sequence broken by a skipped id
          send_fragment(1, 3, $urandom_range(0, PAYLOAD_MAX), 1);
          send_fragment(3, 3, $urandom_range(0, PAYLOAD_MAX), 1);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait_idle();
    $display("%0d requests; %0d fragment results (%0d packets ready), %0d bytes read",
             n_items, n_frag_res, n_ready, n_reads);
    $display("register settings: reset, all zeros, all ones and two random sets");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/fra_pkg.sv
rtl/fra_ram.sv
rtl/fra_ctrl.sv
rtl/fra_datapath.sv
rtl/fragment_reassembler_ip_rewriter.sv
tb/fragment_reassembler_ip_rewriter_test.sv
